[hdl/scsp_pkg.sv]
`default_nettype none

package scsp_pkg;

    localparam logic [1:0] SYM_ONES   = 2'h3;
    localparam logic [3:0] RUN_NEEDED = 4'd12;
    localparam logic [7:0] HDR_BYTE   = 8'hff;

    localparam logic [7:0] SYNC_A = 8'hca;
    localparam logic [7:0] SYNC_B = 8'h80;
    localparam logic [7:0] SYNC_C = 8'h9d;
    localparam logic [7:0] SYNC_D = 8'hb6;

    // result queue: must hold a full header plus whatever is still queued
    localparam int QDEPTH = 8;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);
    localparam int HDR_LEN = 4;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       header_flag;
        logic       last_of_run;
    } t_entry;

    function automatic logic is_sync(input logic [7:0] v);
        return (v == SYNC_A) || (v == SYNC_B) || (v == SYNC_C) || (v == SYNC_D);
    endfunction

    // number of consecutive 3-symbols from bits 7:6 downward
    function automatic logic [3:0] top_ones(input logic [7:0] v);
        logic [3:0] n;
        logic       stop;
        n    = '0;
        stop = 1'b0;
        for (int s = 0; s < 4; s++) begin
            if (!stop) begin
                if (v[7 - 2 * s -: 2] == SYM_ONES) begin
                    n = n + 4'd1;
                end else begin
                    stop = 1'b1;
                end
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

[hdl/serial_camera_symbol_packer_top.sv]
// A result is queued when its sample is accepted; the output shows the queue head.
// One sample per cycle while o_in_stall is low; the sync header leaves as four output
// items, fed from an 8-entry result queue.
// o_in_stall rises only while more than four results are queued (output side stalled).
// Reset (i_rst_n low, synchronous) returns to unlocked search and empties the queue.
`default_nettype none

module serial_camera_symbol_packer_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // sample channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_sample,
    // result channel
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_header_flag,
    output logic            o_last_of_run
);
    import scsp_pkg::*;

    // symbol tracking state
    logic       r_locked,     n_locked;
    logic [3:0] r_ones_run,   n_ones_run;
    logic [7:0] r_cand_byte,  n_cand_byte;
    logic [1:0] r_cand_count, n_cand_count;
    logic [7:0] r_pack_byte,  n_pack_byte;
    logic [1:0] r_pack_count, n_pack_count;

    // result queue
    t_entry           r_q [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0]   r_q_count;

    logic       in_take;
    logic       out_take;
    logic [1:0] sym;
    logic [7:0] cand_next;
    logic [7:0] pack_next;
    logic [2:0] push_cnt;
    t_entry     slot [HDR_LEN];

    assign sym     = i_sample[6:5];
    assign in_take  = i_in_valid && !o_in_stall;
    assign out_take = o_out_valid && !i_out_stall;

    // worst case one item pushes a full header
    assign o_in_stall = (r_q_count > QCW'(QDEPTH - HDR_LEN));

    // new symbol merged at its slot, LSB first
    assign cand_next = r_cand_byte | (8'({6'd0, sym}) << {r_cand_count, 1'b0});
    assign pack_next = r_pack_byte | (8'({6'd0, sym}) << {r_pack_count, 1'b0});

    always_comb begin
        n_locked     = r_locked;
        n_ones_run   = r_ones_run;
        n_cand_byte  = r_cand_byte;
        n_cand_count = r_cand_count;
        n_pack_byte  = r_pack_byte;
        n_pack_count = r_pack_count;
        push_cnt     = 3'd0;
        for (int k = 0; k < HDR_LEN; k++) begin
            slot[k] = '{out_byte: HDR_BYTE, header_flag: 1'b1, last_of_run: 1'b0};
        end

        if (r_locked) begin
            // data mode: every fourth symbol completes a byte
            if (r_pack_count == 2'd3) begin
                slot[0]      = '{out_byte: pack_next, header_flag: 1'b0, last_of_run: 1'b1};
                push_cnt     = 3'd1;
                n_pack_byte  = '0;
                n_pack_count = 2'd0;
            end else begin
                n_pack_byte  = pack_next;
                n_pack_count = r_pack_count + 2'd1;
            end
        end else if (r_cand_count != 2'd0) begin
            // candidate in progress
            if (r_cand_count != 2'd3) begin
                n_cand_byte  = cand_next;
                n_cand_count = r_cand_count + 2'd1;
            end else begin
                n_cand_byte  = '0;
                n_cand_count = 2'd0;
                if (is_sync(cand_next)) begin
                    slot[HDR_LEN-1] = '{out_byte: cand_next, header_flag: 1'b1,
                                        last_of_run: 1'b1};
                    push_cnt   = 3'(HDR_LEN);
                    n_locked   = 1'b1;
                    n_ones_run = '0;
                end else begin
                    // resume run from the candidate's trailing 3-symbols
                    n_ones_run = top_ones(cand_next);
                end
            end
        end else if (sym == SYM_ONES) begin
            if (r_ones_run < RUN_NEEDED) begin
                n_ones_run = r_ones_run + 4'd1;
            end
        end else if (r_ones_run < RUN_NEEDED) begin
            n_ones_run = '0;
        end else begin
            // long enough run: this symbol opens a candidate
            n_cand_byte  = {6'd0, sym};
            n_cand_count = 2'd1;
            n_ones_run   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked     <= 1'b0;
            r_ones_run   <= '0;
            r_cand_byte  <= '0;
            r_cand_count <= '0;
            r_pack_byte  <= '0;
            r_pack_count <= '0;
        end else if (in_take) begin
            r_locked     <= n_locked;
            r_ones_run   <= n_ones_run;
            r_cand_byte  <= n_cand_byte;
            r_cand_count <= n_cand_count;
            r_pack_byte  <= n_pack_byte;
            r_pack_count <= n_pack_count;
        end
    end

    // queue storage, up to a full header written per cycle
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            for (int k = 0; k < HDR_LEN; k++) begin
                if (3'(k) < push_cnt) begin
                    r_q[r_wr_ptr + QAW'(k)] <= slot[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_q_count <= '0;
        end else begin
            if (in_take) begin
                r_wr_ptr <= r_wr_ptr + QAW'(push_cnt);
            end
            if (out_take) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            r_q_count <= r_q_count + (in_take ? QCW'(push_cnt) : QCW'(0))
                         - (out_take ? QCW'(1) : QCW'(0));
        end
    end

    assign o_out_valid   = (r_q_count != '0);
    assign o_out_byte    = r_q[r_rd_ptr].out_byte;
    assign o_header_flag = r_q[r_rd_ptr].header_flag;
    assign o_last_of_run = r_q[r_rd_ptr].last_of_run;

endmodule

`default_nettype wire

[hdl/scsp_checker.sv]
`default_nettype none

module scsp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_header_flag,
    input wire logic       o_last_of_run
);
    import scsp_pkg::*;

    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_header_flag) && $stable(o_last_of_run))
        else $error("stalled result changed");

    // input backpressure only comes from a backed-up result queue
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result queue");

    // data bytes are single results
    a_data_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_header_flag |-> o_last_of_run)
        else $error("data byte not last of its item");

    // leading header bytes are the fill byte
    a_hdr_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_header_flag && !o_last_of_run |-> o_out_byte == HDR_BYTE)
        else $error("bad header fill byte");

    // closing header byte is a sync code
    a_hdr_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_header_flag && o_last_of_run |->
            o_out_byte == SYNC_A || o_out_byte == SYNC_B
            || o_out_byte == SYNC_C || o_out_byte == SYNC_D)
        else $error("header closed by non-sync code");

endmodule

bind serial_camera_symbol_packer_top scsp_checker u_scsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_byte    (o_out_byte),
    .o_header_flag (o_header_flag),
    .o_last_of_run (o_last_of_run)
);

`default_nettype wire
